// ----- hw/rtl/scp_pkg.sv -----
// Shared types and constants of the serial command parser.
package scp_pkg;

   localparam logic [7:0] CHAR_START   = 8'h73; // 's'
   localparam logic [7:0] CHAR_STOP    = 8'h70; // 'p'
   localparam logic [7:0] CHAR_GAIN    = 8'h67; // 'g'
   localparam logic [7:0] CHAR_RATE    = 8'h76; // 'v'
   localparam logic [7:0] CHAR_WINDOW  = 8'h62; // 'b'
   localparam logic [7:0] CHAR_SEND    = 8'h74; // 't'

   localparam logic [9:0] GAIN_MAX     = 10'd6;
   localparam logic [9:0] RATE_MAX     = 10'd12;
   localparam logic [9:0] WINDOW_MAX   = 10'd128;

   localparam logic [2:0] GAIN_RESET   = 3'd3;
   localparam logic [3:0] RATE_RESET   = 4'd0;
   localparam logic [7:0] WINDOW_RESET = 8'd16;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_GAIN     = 3'd1,
      PH_RATE_HI  = 3'd2,
      PH_RATE_LO  = 3'd3,
      PH_RATE_END = 3'd4,
      PH_WIN_HUN  = 3'd5,
      PH_WIN_TEN  = 3'd6,
      PH_WIN_ONE  = 3'd7
   } phase_type;

   typedef enum logic [3:0] {
      MSG_NONE         = 4'd0,
      MSG_STOPPED      = 4'd1,
      MSG_BAD_CMD      = 4'd2,
      MSG_GAIN_SET     = 4'd3,
      MSG_GAIN_DIGIT   = 4'd4,
      MSG_GAIN_RANGE   = 4'd5,
      MSG_RATE_DIGIT1  = 4'd6,
      MSG_RATE_DIGIT2  = 4'd7,
      MSG_RATE_SET     = 4'd8,
      MSG_RATE_RANGE   = 4'd9,
      MSG_WIN_DIGIT1   = 4'd10,
      MSG_WIN_DIGIT2   = 4'd11,
      MSG_WIN_DIGIT3   = 4'd12,
      MSG_WIN_SET      = 4'd13,
      MSG_WIN_RANGE    = 4'd14
   } msg_type;

   typedef struct packed {
      phase_type   phase;
      logic        stop;
      logic [9:0]  accum;
      logic [2:0]  gain;
      logic [3:0]  rate;
      logic [7:0]  window;
   } parse_state_type;

   typedef struct packed {
      msg_type     message;
      logic        restart;
      logic        send;
   } step_flags_type;

endpackage

// ----- hw/rtl/scp_step.sv -----
// Combinational decode of one character against the current parser state.
module scp_step (
   input  scp_pkg::parse_state_type cur_state,
   input  logic [7:0]               rx_char,
   output scp_pkg::parse_state_type next_state,
   output scp_pkg::step_flags_type  flags
);

   logic       is_digit;
   logic [9:0] digit;
   logic [9:0] sum_one;
   logic [9:0] sum_ten;

   // ASCII digits are 0x30..0x39, so the value is the low nibble.
   assign is_digit = (rx_char[7:4] == 4'h3) && (rx_char[3:0] <= 4'd9);
   assign digit    = {6'd0, rx_char[3:0]};
   assign sum_one  = cur_state.accum + digit;
   assign sum_ten  = cur_state.accum + 10'((digit << 3) + (digit << 1));

   always_comb begin
      next_state       = cur_state;
      next_state.phase = scp_pkg::PH_IDLE;
      flags.message    = scp_pkg::MSG_NONE;
      flags.restart    = 1'b0;
      flags.send       = 1'b0;

      unique case (cur_state.phase)
         scp_pkg::PH_IDLE: begin
            case (rx_char)
               scp_pkg::CHAR_START: begin
                  next_state.stop = 1'b0;
                  flags.restart   = 1'b1;
               end
               scp_pkg::CHAR_STOP: begin
                  next_state.stop = 1'b1;
                  flags.message   = scp_pkg::MSG_STOPPED;
               end
               scp_pkg::CHAR_GAIN: begin
                  if (cur_state.stop) next_state.phase = scp_pkg::PH_GAIN;
               end
               scp_pkg::CHAR_RATE: begin
                  if (cur_state.stop) next_state.phase = scp_pkg::PH_RATE_HI;
               end
               scp_pkg::CHAR_WINDOW: begin
                  if (cur_state.stop) next_state.phase = scp_pkg::PH_WIN_HUN;
               end
               scp_pkg::CHAR_SEND: begin
                  flags.send = 1'b1;
               end
               default: begin
                  flags.message = scp_pkg::MSG_BAD_CMD;
               end
            endcase
         end
         scp_pkg::PH_GAIN: begin
            if (!is_digit) begin
               flags.message = scp_pkg::MSG_GAIN_DIGIT;
            end else begin
               next_state.accum = digit;
               if (digit <= scp_pkg::GAIN_MAX) begin
                  next_state.gain = digit[2:0];
                  flags.message   = scp_pkg::MSG_GAIN_SET;
               end else begin
                  flags.message   = scp_pkg::MSG_GAIN_RANGE;
               end
            end
         end
         scp_pkg::PH_RATE_HI: begin
            if (!is_digit) begin
               flags.message = scp_pkg::MSG_RATE_DIGIT1;
            end else begin
               next_state.accum = 10'((digit << 3) + (digit << 1));
               next_state.phase = scp_pkg::PH_RATE_LO;
            end
         end
         scp_pkg::PH_RATE_LO: begin
            if (!is_digit) begin
               flags.message = scp_pkg::MSG_RATE_DIGIT2;
            end else begin
               next_state.accum = sum_one;
               next_state.phase = scp_pkg::PH_RATE_END;
            end
         end
         scp_pkg::PH_RATE_END: begin
            // The trailing character is consumed whatever its value.
            if (cur_state.accum <= scp_pkg::RATE_MAX) begin
               next_state.rate = cur_state.accum[3:0];
               flags.message   = scp_pkg::MSG_RATE_SET;
            end else begin
               flags.message   = scp_pkg::MSG_RATE_RANGE;
            end
         end
         scp_pkg::PH_WIN_HUN: begin
            if (!is_digit) begin
               flags.message = scp_pkg::MSG_WIN_DIGIT1;
            end else begin
               next_state.accum = 10'((digit << 6) + (digit << 5) + (digit << 2));
               next_state.phase = scp_pkg::PH_WIN_TEN;
            end
         end
         scp_pkg::PH_WIN_TEN: begin
            if (!is_digit) begin
               flags.message = scp_pkg::MSG_WIN_DIGIT2;
            end else begin
               next_state.accum = sum_ten;
               next_state.phase = scp_pkg::PH_WIN_ONE;
            end
         end
         scp_pkg::PH_WIN_ONE: begin
            if (!is_digit) begin
               flags.message = scp_pkg::MSG_WIN_DIGIT3;
            end else begin
               next_state.accum = sum_one;
               if (sum_one <= scp_pkg::WINDOW_MAX) begin
                  next_state.window = sum_one[7:0];
                  flags.message     = scp_pkg::MSG_WIN_SET;
               end else begin
                  flags.message     = scp_pkg::MSG_WIN_RANGE;
               end
            end
         end
         default: begin
            next_state.phase = scp_pkg::PH_IDLE;
         end
      endcase
   end

endmodule

// ----- hw/rtl/scp_settings.sv -----
// Parser state register: phase, stop flag, accumulator and the settings.
module scp_settings (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  scp_pkg::parse_state_type state_in,
   output scp_pkg::parse_state_type state_ff
);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase  <= scp_pkg::PH_IDLE;
         state_ff.stop   <= 1'b0;
         state_ff.accum  <= 10'd0;
         state_ff.gain   <= scp_pkg::GAIN_RESET;
         state_ff.rate   <= scp_pkg::RATE_RESET;
         state_ff.window <= scp_pkg::WINDOW_RESET;
      end else if (load) begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hw/rtl/serial_command_parser.sv -----
// Top level of the serial command parser: input register, step logic, result register.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_ready  rx_char (8 bits)
//   rsp_      out        rsp_valid / rsp_ready  message, stopped, gain_code, rate_code,
//                                               window_size, restart_pulse, send_pulse
//
// Each character produces exactly one result transfer; it passes through the input
// register and then the result register. Both the input register and the result
// register can each hold one transfer, so one character is taken every cycle while
// the result side is ready; the single parse step between the two registers is combinational.
// A stall on the result side holds the result register and, once the input register
// is also full, drops req_ready. Reset is synchronous and active high; it empties
// both registers and restores the default settings (gain 3, rate 0, window 16).
module serial_command_parser (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_char,

   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_message,
   output logic       rsp_stopped,
   output logic [2:0] rsp_gain_code,
   output logic [3:0] rsp_rate_code,
   output logic [7:0] rsp_window_size,
   output logic       rsp_restart_pulse,
   output logic       rsp_send_pulse
);

   // Input register: one character waiting for the parse step.
   logic       in_valid_ff;
   logic [7:0] in_char_ff;

   // Result register.
   logic       out_valid_ff;
   logic [3:0] out_message_ff;
   logic       out_stopped_ff;
   logic [2:0] out_gain_ff;
   logic [3:0] out_rate_ff;
   logic [7:0] out_window_ff;
   logic       out_restart_ff;
   logic       out_send_ff;

   scp_pkg::parse_state_type state_ff;
   scp_pkg::parse_state_type state_in;
   scp_pkg::step_flags_type  flags;

   logic advance;
   logic req_take;

   // The held character moves into the result register when that register is empty
   // or is being emptied in this cycle. The parser state updates at the same edge,
   // so characters are always processed in arrival order.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   scp_step u_step (
      .cur_state  (state_ff),
      .rx_char    (in_char_ff),
      .next_state (state_in),
      .flags      (flags)
   );

   scp_settings u_settings (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .state_in (state_in),
      .state_ff (state_ff)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_rx_char;
      end
      if (advance) begin
         // The result reports the settings as they stand after this character.
         out_message_ff <= flags.message;
         out_restart_ff <= flags.restart;
         out_send_ff    <= flags.send;
         out_stopped_ff <= state_in.stop;
         out_gain_ff    <= state_in.gain;
         out_rate_ff    <= state_in.rate;
         out_window_ff  <= state_in.window;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_message       = out_message_ff;
   assign rsp_stopped       = out_stopped_ff;
   assign rsp_gain_code     = out_gain_ff;
   assign rsp_rate_code     = out_rate_ff;
   assign rsp_window_size   = out_window_ff;
   assign rsp_restart_pulse = out_restart_ff;
   assign rsp_send_pulse    = out_send_ff;

   // A restart always clears the stop flag.
   a_restart_runs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_restart_pulse |-> !rsp_stopped)
      else $error("restart reported while stopped");

   // A character is either a restart or a dump request, never both.
   a_pulse_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_restart_pulse && rsp_send_pulse))
      else $error("restart and send pulses together");

   // Settings never leave their legal ranges.
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_gain_code <= 3'd6)
      else $error("gain code out of range");

   a_rate_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_rate_code <= 4'd12)
      else $error("rate code out of range");

   a_window_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_window_size <= 8'd128)
      else $error("window size out of range");

endmodule

// ----- tb/tb_serial_command_parser.sv -----
// Self-checking testbench for the serial command parser, with a predicting scoreboard.
`timescale 1ns / 1ps

module tb_serial_command_parser;

   // Total characters to send: a directed opening followed by random commands.
   localparam int ITEM_COUNT     = 1550;
   // Idle gaps on either side are at most GAP_MAX and the block adds its two registers,
   // so reaching WATCHDOG_LIMIT without any transfer can only mean a hang.
   localparam int WATCHDOG_LIMIT = 400;
   localparam int DRAIN_CYCLES   = 10;
   localparam int GAP_MAX        = 17;

   localparam logic [7:0] DIGIT_ZERO = 8'h30;
   localparam logic [7:0] DIGIT_NINE = 8'h39;

   // One response of the parser, as the result channel carries it.
   typedef struct packed {
      scp_pkg::msg_type message;
      logic             stopped;
      logic [2:0]       gain_code;
      logic [3:0]       rate_code;
      logic [7:0]       window_size;
      logic             restart_pulse;
      logic             send_pulse;
   } response_type;

   // The scoreboard keeps its own copy of the parser state, predicts the response
   // to every accepted character and checks the responses in order.
   class parser_scoreboard;
      response_type       pending[$];
      scp_pkg::phase_type phase;
      logic               stop;
      logic [9:0]         accum;
      logic [2:0]         gain;
      logic [3:0]         rate;
      logic [7:0]         window;
      int                 failures;
      int                 checked;
      int                 chars;
      int                 msg_seen[16];

      function new();
         phase    = scp_pkg::PH_IDLE;
         stop     = 1'b0;
         accum    = '0;
         gain     = scp_pkg::GAIN_RESET;
         rate     = scp_pkg::RATE_RESET;
         window   = scp_pkg::WINDOW_RESET;
         failures = 0;
         checked  = 0;
         chars    = 0;
         foreach (msg_seen[i]) msg_seen[i] = 0;
      endfunction

      function void predict_char(logic [7:0] c);
         logic [9:0]         digit;
         bit                 is_dig;
         response_type       r;
         scp_pkg::phase_type next_phase;
         digit      = 10'(c - DIGIT_ZERO);
         is_dig     = (c >= DIGIT_ZERO) && (c <= DIGIT_NINE);
         r          = '0;
         r.message  = scp_pkg::MSG_NONE;
         next_phase = scp_pkg::PH_IDLE;
         case (phase)
            scp_pkg::PH_IDLE: begin
               if (c == scp_pkg::CHAR_START) begin
                  stop = 1'b0;
                  r.restart_pulse = 1'b1;
               end else if (c == scp_pkg::CHAR_STOP) begin
                  stop = 1'b1;
                  r.message = scp_pkg::MSG_STOPPED;
               end else if (c == scp_pkg::CHAR_GAIN) begin
                  // Argument commands only open a phase while stopped.
                  if (stop) next_phase = scp_pkg::PH_GAIN;
               end else if (c == scp_pkg::CHAR_RATE) begin
                  if (stop) next_phase = scp_pkg::PH_RATE_HI;
               end else if (c == scp_pkg::CHAR_WINDOW) begin
                  if (stop) next_phase = scp_pkg::PH_WIN_HUN;
               end else if (c == scp_pkg::CHAR_SEND) begin
                  r.send_pulse = 1'b1;
               end else begin
                  r.message = scp_pkg::MSG_BAD_CMD;
               end
            end
            scp_pkg::PH_GAIN: begin
               if (!is_dig) begin
                  r.message = scp_pkg::MSG_GAIN_DIGIT;
               end else begin
                  accum = digit;
                  if (accum <= scp_pkg::GAIN_MAX) begin
                     gain = accum[2:0];
                     r.message = scp_pkg::MSG_GAIN_SET;
                  end else begin
                     r.message = scp_pkg::MSG_GAIN_RANGE;
                  end
               end
            end
            scp_pkg::PH_RATE_HI: begin
               if (!is_dig) begin
                  r.message = scp_pkg::MSG_RATE_DIGIT1;
               end else begin
                  accum = 10'(digit * 10);
                  next_phase = scp_pkg::PH_RATE_LO;
               end
            end
            scp_pkg::PH_RATE_LO: begin
               if (!is_dig) begin
                  r.message = scp_pkg::MSG_RATE_DIGIT2;
               end else begin
                  accum = accum + digit;
                  next_phase = scp_pkg::PH_RATE_END;
               end
            end
            scp_pkg::PH_RATE_END: begin
               // Any character ends the rate command; only now is the range known.
               if (accum <= scp_pkg::RATE_MAX) begin
                  rate = accum[3:0];
                  r.message = scp_pkg::MSG_RATE_SET;
               end else begin
                  r.message = scp_pkg::MSG_RATE_RANGE;
               end
            end
            scp_pkg::PH_WIN_HUN: begin
               if (!is_dig) begin
                  r.message = scp_pkg::MSG_WIN_DIGIT1;
               end else begin
                  accum = 10'(digit * 100);
                  next_phase = scp_pkg::PH_WIN_TEN;
               end
            end
            scp_pkg::PH_WIN_TEN: begin
               if (!is_dig) begin
                  r.message = scp_pkg::MSG_WIN_DIGIT2;
               end else begin
                  accum = 10'(accum + digit * 10);
                  next_phase = scp_pkg::PH_WIN_ONE;
               end
            end
            default: begin
               if (!is_dig) begin
                  r.message = scp_pkg::MSG_WIN_DIGIT3;
               end else begin
                  accum = accum + digit;
                  if (accum <= scp_pkg::WINDOW_MAX) begin
                     window = accum[7:0];
                     r.message = scp_pkg::MSG_WIN_SET;
                  end else begin
                     r.message = scp_pkg::MSG_WIN_RANGE;
                  end
               end
            end
         endcase
         phase         = next_phase;
         r.stopped     = stop;
         r.gain_code   = gain;
         r.rate_code   = rate;
         r.window_size = window;
         pending.push_back(r);
         chars++;
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_response(response_type got);
         response_type want;
         if (pending.size() == 0) begin
            $error("response transfer with no character outstanding");
            failures++;
            return;
         end
         want = pending.pop_front();
         checked++;
         msg_seen[int'(want.message)]++;
         compare_field("message", 8'(want.message), 8'(got.message));
         compare_field("stopped", 8'(want.stopped), 8'(got.stopped));
         compare_field("gain_code", 8'(want.gain_code), 8'(got.gain_code));
         compare_field("rate_code", 8'(want.rate_code), 8'(got.rate_code));
         compare_field("window_size", want.window_size, got.window_size);
         compare_field("restart_pulse", 8'(want.restart_pulse), 8'(got.restart_pulse));
         compare_field("send_pulse", 8'(want.send_pulse), 8'(got.send_pulse));
      endfunction
   endclass

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_char = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   logic [3:0] rsp_message;
   logic       rsp_stopped;
   logic [2:0] rsp_gain_code;
   logic [3:0] rsp_rate_code;
   logic [7:0] rsp_window_size;
   logic       rsp_restart_pulse;
   logic       rsp_send_pulse;

   parser_scoreboard sb;
   int  sent_count  = 0;
   int  idle_cycles = 0;
   // While a quiet flag is set, that side runs back to back with no idle cycles.
   bit  send_quiet  = 1'b0;
   bit  recv_quiet  = 1'b0;

   serial_command_parser i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_char       (req_rx_char),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_message       (rsp_message),
      .rsp_stopped       (rsp_stopped),
      .rsp_gain_code     (rsp_gain_code),
      .rsp_rate_code     (rsp_rate_code),
      .rsp_window_size   (rsp_window_size),
      .rsp_restart_pulse (rsp_restart_pulse),
      .rsp_send_pulse    (rsp_send_pulse)
   );

   always #5 clock = ~clock;

   // Sends one character. The task is entered at a rising edge and returns at the
   // edge where the transfer took place. Valid is lowered only when a gap follows,
   // so back-to-back characters never see valid dropped and raised in one step.
   task automatic send_char(input logic [7:0] c);
      int gap;
      gap = send_quiet ? 0 : $urandom_range(0, GAP_MAX);
      if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_char <= c;
      do @(posedge clock); while (!req_ready);
      sb.predict_char(c);
      sent_count++;
   endtask

   function automatic logic [7:0] non_digit();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c >= DIGIT_ZERO && c <= DIGIT_NINE);
      return c;
   endfunction

   // A decimal argument character from 0 to hi, now and then replaced by garbage
   // so that every digit-error path gets exercised.
   function automatic logic [7:0] arg_char(int hi);
      if ($urandom_range(0, 11) == 0) return non_digit();
      return DIGIT_ZERO + 8'($urandom_range(0, hi));
   endfunction

   // One random command. Stop commands are frequent so that most argument
   // commands find the parser stopped and run through their digit phases;
   // leading digits favor small values so both in-range and range errors occur.
   task automatic send_random_command();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         send_char(8'($urandom_range(0, 255)));
      end else if (pick < 14) begin
         send_char(scp_pkg::CHAR_START);
      end else if (pick < 30) begin
         send_char(scp_pkg::CHAR_STOP);
      end else if (pick < 36) begin
         send_char(scp_pkg::CHAR_SEND);
      end else if (pick < 54) begin
         send_char(scp_pkg::CHAR_GAIN);
         send_char(arg_char(9));
      end else if (pick < 74) begin
         send_char(scp_pkg::CHAR_RATE);
         send_char(arg_char(($urandom_range(0, 3) == 0) ? 9 : 1));
         send_char(arg_char(9));
         send_char(8'($urandom_range(0, 255)));
      end else begin
         send_char(scp_pkg::CHAR_WINDOW);
         send_char(arg_char(($urandom_range(0, 3) == 0) ? 9 : 1));
         send_char(arg_char(($urandom_range(0, 3) == 0) ? 9 : 2));
         send_char(arg_char(9));
      end
   endtask

   // Directed opening: an argument command while running, the byte extremes as unknown
   // commands, every command letter, a value at each limit and one out of range, the
   // rate command's trailing character, and a non-digit in the rate and window commands.
   logic [7:0] directed_chars[$] = '{
      scp_pkg::CHAR_GAIN, 8'h00, 8'hFF, scp_pkg::CHAR_SEND, scp_pkg::CHAR_START,
      scp_pkg::CHAR_STOP,
      scp_pkg::CHAR_GAIN, "6", scp_pkg::CHAR_GAIN, "7",
      scp_pkg::CHAR_RATE, "1", "2", 8'hFF,
      scp_pkg::CHAR_RATE, "9", "9", "0",
      scp_pkg::CHAR_RATE, "/",
      scp_pkg::CHAR_WINDOW, "1", "2", "8",
      scp_pkg::CHAR_WINDOW, "9", "9", "9",
      scp_pkg::CHAR_WINDOW, ":"
   };

   // Stimulus and end of run.
   initial begin
      int codes;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_chars[i]) send_char(directed_chars[i]);
      while (sent_count < ITEM_COUNT) send_random_command();
      req_valid <= 1'b0;
      // The watchdog ends the run if the responses never all arrive.
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      codes = 0;
      foreach (sb.msg_seen[i]) if (sb.msg_seen[i] > 0) codes++;
      $display("Run covered %0d characters and %0d checked responses.",
               sb.chars, sb.checked);
      $display("%0d distinct message codes came up; %0d field mismatches were found.",
               codes, sb.failures);
      if (sb.failures == 0 && sb.pending.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Response side: stalls a random number of cycles before each response, with
   // quiet stretches of continuous ready. Outputs are read at the rising edge,
   // before the block's registers update.
   initial begin
      int           stall;
      response_type got;
      do @(posedge clock); while (reset);
      forever begin
         stall = recv_quiet ? 0 : $urandom_range(0, GAP_MAX);
         if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got.message       = scp_pkg::msg_type'(rsp_message);
         got.stopped       = rsp_stopped;
         got.gain_code     = rsp_gain_code;
         got.rate_code     = rsp_rate_code;
         got.window_size   = rsp_window_size;
         got.restart_pulse = rsp_restart_pulse;
         got.send_pulse    = rsp_send_pulse;
         sb.check_response(got);
      end
   end

   // Watchdog: counts cycles in which neither channel makes a transfer.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired after %0d cycles without a transfer.", idle_cycles);
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// ----- sim.f -----
hw/rtl/scp_pkg.sv
hw/rtl/scp_step.sv
hw/rtl/scp_settings.sv
hw/rtl/serial_command_parser.sv
tb/tb_serial_command_parser.sv
